/* hdl/lbcs_pkg.sv */
// ============================================================================
// lbcs_pkg
// Shared types and constants for the LED blink-code sequencer.
// ============================================================================
`default_nettype none

package lbcs_pkg;

    // Widths of the pulse counts and of the running unit counter.
    localparam int SolarCountWidth   = 7;   // (65535 + 500) / 1000 = 66
    localparam int BatteryCountWidth = 9;   // (65535 + 100) / 200  = 328
    localparam int LoadCountWidth    = 7;
    localparam int UnitsWidth        = 10;  // 66 + 328 + 66 = 460
    localparam int TimeWidth         = 16;
    localparam int WeightWidth       = 4;
    localparam int CfgIndexWidth     = 3;

    // Register reset values.
    localparam logic [TimeWidth-1:0]   OffTimeReset     = 16'd250;
    localparam logic [TimeWidth-1:0]   GapTimeReset     = 16'd750;
    localparam logic [TimeWidth-1:0]   ShortOnTimeReset = 16'd250;
    localparam logic [TimeWidth-1:0]   LongOnTimeReset  = 16'd500;
    localparam logic [WeightWidth-1:0] LongWeightReset  = 4'd5;

    // Register indexes on the configuration port.
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_OFF_TIME      = 3'd0,
        REG_GAP_TIME      = 3'd1,
        REG_SHORT_ON_TIME = 3'd2,
        REG_LONG_ON_TIME  = 3'd3,
        REG_LONG_WEIGHT   = 3'd4
    } cfg_index_t;

    // Input operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [TimeWidth-1:0]   off_time;
        logic [TimeWidth-1:0]   gap_time;
        logic [TimeWidth-1:0]   short_on_time;
        logic [TimeWidth-1:0]   long_on_time;
        logic [WeightWidth-1:0] long_weight;
    } cfg_t;

    typedef struct packed {
        logic [TimeWidth-1:0]         wait_count;
        logic [SolarCountWidth-1:0]   solar_count;
        logic [BatteryCountWidth-1:0] battery_count;
        logic [LoadCountWidth-1:0]    load_count;
        logic [UnitsWidth-1:0]        units_shown;
        logic                         lamp_lit;
        logic                         green_level;
        logic                         red_level;
    } seq_state_t;

    typedef struct packed {
        logic [SolarCountWidth-1:0]   solar_count;
        logic [BatteryCountWidth-1:0] battery_count;
        logic [LoadCountWidth-1:0]    load_count;
    } counts_t;

    typedef struct packed {
        logic green_on;
        logic red_on;
        logic busy_res;
    } result_t;

endpackage

`default_nettype wire

/* hdl/led_blink_code_sequencer.sv */
// ============================================================================
// led_blink_code_sequencer
// Shows solar, battery and load readings as pulse codes on a two-color LED.
// ============================================================================
// The slave channel carries one transaction per millisecond tick (tuser = 0)
// or a start (tuser = 1) with three readings in tdata. A start rounds solar
// and load power to whole watts and battery voltage to 200 mV steps, then
// blinks green for solar, yellow for battery and red for load, using long
// pulses worth long_weight units where they fit and short pulses otherwise.
// A start during a sequence restarts it.
//
// Every slave transaction produces exactly one master transaction holding
// the LED levels and a busy flag after that step. The readings are rounded
// by reciprocal multipliers into the input register; the sequencer step runs
// between the input register and the result register. A result is presented
// once its transaction has passed through both registers, and while the
// receiver does not stall one transaction is taken per cycle.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready falls only when both are occupied.
// Reset (aresetn low, synchronous) loads the register defaults, turns the
// LED off and empties both stages. Configuration writes via cfg_wr_en take
// effect at the next edge and are meant to happen only while idle.
// ============================================================================
`default_nettype none

module led_blink_code_sequencer
    import lbcs_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Configuration write port.
    input  wire logic                     cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [TimeWidth-1:0]     cfg_wdata,
    // Input channel.
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [47:0]              s_tdata,  // solar_power_mw, battery_mv, load_power_mw
    input  wire logic                     s_tuser,  // operation
    // Result channel.
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [7:0]                    m_tdata   // green_on, red_on, busy_res, zero pad
);

    cfg_t       cfg_reg;
    seq_state_t st_reg;
    seq_state_t st_next;
    counts_t    counts_round;
    counts_t    in_counts_reg;
    logic       in_start_reg;
    logic       in_valid_reg;
    result_t    step_result;
    result_t    out_result_reg;
    logic       out_valid_reg;
    logic       step_fire;
    logic       in_accept;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_time      <= OffTimeReset;
            cfg_reg.gap_time      <= GapTimeReset;
            cfg_reg.short_on_time <= ShortOnTimeReset;
            cfg_reg.long_on_time  <= LongOnTimeReset;
            cfg_reg.long_weight   <= LongWeightReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OFF_TIME:      cfg_reg.off_time      <= cfg_wdata;
                REG_GAP_TIME:      cfg_reg.gap_time      <= cfg_wdata;
                REG_SHORT_ON_TIME: cfg_reg.short_on_time <= cfg_wdata;
                REG_LONG_ON_TIME:  cfg_reg.long_on_time  <= cfg_wdata;
                REG_LONG_WEIGHT:   cfg_reg.long_weight   <= cfg_wdata[WeightWidth-1:0];
                default: ;
            endcase
        end
    end

    // The step runs whenever the input stage holds a transaction and the
    // result register is empty or being drained this cycle.
    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;
    assign in_accept = s_tvalid && s_tready;

    lbcs_round u_round (
        .solar_power_mw (s_tdata[15:0]),
        .battery_mv     (s_tdata[31:16]),
        .load_power_mw  (s_tdata[47:32]),
        .counts         (counts_round)
    );

    // Input stage: rounded counts and the operation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (step_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_counts_reg <= counts_round;
            in_start_reg  <= (s_tuser == OP_START);
        end
    end

    lbcs_step u_step (
        .cfg        (cfg_reg),
        .state      (st_reg),
        .start      (in_start_reg),
        .counts     (in_counts_reg),
        .state_next (st_next),
        .result     (step_result)
    );

    // Sequencer state, updated once per stepped transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (step_fire) begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_result_reg.busy_res, out_result_reg.red_on,
                       out_result_reg.green_on};

    // The input stage only refuses data when both stages are full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stage blocked without a downstream stall");

    // The unit counter never runs past the total of the three counts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.units_shown <= (UnitsWidth'(st_reg.solar_count) +
                               UnitsWidth'(st_reg.battery_count) +
                               UnitsWidth'(st_reg.load_count)))
        else $error("units shown exceeds the pulse total");

    // A lit LED always means the last result reported a busy sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.lamp_lit |-> out_result_reg.busy_res)
        else $error("LED lit while result reports idle");

    // A stepped transaction always shows up in the result register next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> out_valid_reg)
        else $error("stepped transaction lost");

endmodule

`default_nettype wire

/* hdl/lbcs_round.sv */
// ============================================================================
// lbcs_round
// Rounds the three readings to pulse counts by reciprocal multiplication.
// ============================================================================
`default_nettype none

module lbcs_round
    import lbcs_pkg::*;
(
    input  wire logic [15:0] solar_power_mw,
    input  wire logic [15:0] battery_mv,
    input  wire logic [15:0] load_power_mw,
    output counts_t          counts
);

    // x / 1000 == (x * 134218) >> 27 and x / 200 == (x * 167773) >> 25,
    // both exact for every x below 2^17.
    localparam logic [17:0] RecipKilo  = 18'd134218;
    localparam logic [17:0] RecipBatt  = 18'd167773;
    localparam logic [16:0] HalfKilo   = 17'd500;
    localparam logic [16:0] HalfBatt   = 17'd100;

    logic [16:0] solar_sum;
    logic [16:0] batt_sum;
    logic [16:0] load_sum;
    logic [34:0] solar_prod;
    logic [34:0] batt_prod;
    logic [34:0] load_prod;

    assign solar_sum  = {1'b0, solar_power_mw} + HalfKilo;
    assign batt_sum   = {1'b0, battery_mv} + HalfBatt;
    assign load_sum   = {1'b0, load_power_mw} + HalfKilo;

    assign solar_prod = {18'd0, solar_sum} * {17'd0, RecipKilo};
    assign batt_prod  = {18'd0, batt_sum} * {17'd0, RecipBatt};
    assign load_prod  = {18'd0, load_sum} * {17'd0, RecipKilo};

    assign counts.solar_count   = solar_prod[33:27];
    assign counts.battery_count = batt_prod[33:25];
    assign counts.load_count    = load_prod[33:27];

endmodule

`default_nettype wire

/* hdl/lbcs_step.sv */
// ============================================================================
// lbcs_step
// Next-state and result logic for one tick or start transaction.
// ============================================================================
`default_nettype none

module lbcs_step
    import lbcs_pkg::*;
(
    input  wire cfg_t       cfg,
    input  wire seq_state_t state,
    input  wire logic       start,
    input  wire counts_t    counts,
    output seq_state_t      state_next,
    output result_t         result
);

    seq_state_t            cur;
    logic [UnitsWidth-1:0] total;
    logic [UnitsWidth-1:0] solar_w;
    logic [UnitsWidth-1:0] battery_w;
    logic [UnitsWidth-1:0] load_w;
    logic [UnitsWidth-1:0] done_units;
    logic [UnitsWidth-1:0] meas_count;
    logic [UnitsWidth:0]   long_end;
    logic [WeightWidth-1:0] weight;
    logic [TimeWidth-1:0]  duration;
    logic [TimeWidth:0]    wait_sum;
    logic                  seq_done;
    logic                  pulse_green;
    logic                  pulse_red;
    logic                  use_long;

    function automatic logic [TimeWidth-1:0] at_least_one(input logic [TimeWidth-1:0] v);
        return (v == '0) ? TimeWidth'(1) : v;
    endfunction

    // A start replaces the counts and rewinds the sequence before stepping.
    always_comb begin
        cur = state;
        if (start) begin
            cur.solar_count   = counts.solar_count;
            cur.battery_count = counts.battery_count;
            cur.load_count    = counts.load_count;
            cur.units_shown   = '0;
            cur.lamp_lit      = 1'b0;
            cur.wait_count    = '0;
        end
    end

    assign solar_w   = UnitsWidth'(cur.solar_count);
    assign battery_w = UnitsWidth'(cur.battery_count);
    assign load_w    = UnitsWidth'(cur.load_count);
    assign total     = solar_w + battery_w + load_w;
    assign seq_done  = !cur.lamp_lit && (cur.units_shown >= total);
    assign weight    = (cfg.long_weight == '0) ? WeightWidth'(1) : cfg.long_weight;

    // Pick the measurement whose pulses are being shown.
    always_comb begin
        if (cur.units_shown < solar_w) begin
            done_units  = cur.units_shown;
            meas_count  = solar_w;
            pulse_green = 1'b1;
            pulse_red   = 1'b0;
        end else if ((cur.units_shown - solar_w) < battery_w) begin
            done_units  = cur.units_shown - solar_w;
            meas_count  = battery_w;
            pulse_green = 1'b1;
            pulse_red   = 1'b1;
        end else begin
            done_units  = cur.units_shown - solar_w - battery_w;
            meas_count  = load_w;
            pulse_green = 1'b0;
            pulse_red   = 1'b1;
        end
    end

    assign long_end = {1'b0, done_units} + (UnitsWidth + 1)'(weight);
    assign use_long = (long_end <= {1'b0, meas_count});

    always_comb begin
        state_next = cur;
        duration   = at_least_one(cfg.off_time);
        if (cur.lamp_lit) begin
            if ((cur.units_shown == solar_w) || (cur.units_shown == solar_w + battery_w)) begin
                duration = at_least_one(cfg.gap_time);
            end else begin
                duration = at_least_one(cfg.off_time);
            end
        end else if (use_long) begin
            duration = at_least_one(cfg.long_on_time);
        end else begin
            duration = at_least_one(cfg.short_on_time);
        end
        // The wait count is zero or one at a transition; one carries over.
        wait_sum = {1'b0, cur.wait_count} + {1'b0, duration} - (TimeWidth + 1)'(1);

        if (!seq_done) begin
            if (cur.wait_count > TimeWidth'(1)) begin
                state_next.wait_count = cur.wait_count - TimeWidth'(1);
            end else begin
                state_next.wait_count = wait_sum[TimeWidth-1:0];
                if (cur.lamp_lit) begin
                    state_next.lamp_lit    = 1'b0;
                    state_next.green_level = 1'b0;
                    state_next.red_level   = 1'b0;
                end else begin
                    state_next.lamp_lit    = 1'b1;
                    state_next.green_level = pulse_green;
                    state_next.red_level   = pulse_red;
                    if (use_long) begin
                        state_next.units_shown = cur.units_shown + UnitsWidth'(weight);
                    end else begin
                        state_next.units_shown = cur.units_shown + UnitsWidth'(1);
                    end
                end
            end
        end
    end

    assign result.green_on = state_next.green_level;
    assign result.red_on   = state_next.red_level;
    assign result.busy_res = !(!state_next.lamp_lit && (state_next.units_shown >= total));

endmodule

`default_nettype wire

/* tb/led_blink_code_sequencer_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// led_blink_code_sequencer_test
// Self-checking testbench for the LED blink-code sequencer.
// ============================================================================
// Start and tick transactions are sent on the slave channel. Each accepted
// transaction is run through a cycle-free model of the sequencer kept in this
// file, and the LED levels and busy flag it predicts are queued. Every master
// transaction is compared against the oldest queued prediction. Directed
// tests cover rounding boundaries, a start while the LED is lit, full-scale
// readings with a restart and zero-valued registers; a random test then runs
// several register settings with gaps on the sender and stalls on the
// receiver.
// ============================================================================

module led_blink_code_sequencer_test;
    import lbcs_pkg::*;

    localparam int CycleLimit = 400_000;
    localparam int MaxReports = 10;
    localparam int Latency    = 2;
    localparam int Phases     = 8;
    localparam int PhaseItems = 85;

    // DUT connections. Every input is known from time zero.
    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = REG_OFF_TIME;
    logic [TimeWidth-1:0]     cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [47:0]              s_tdata   = '0;  // solar_power_mw, battery_mv, load_power_mw
    logic                     s_tuser   = OP_TICK;  // operation
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [7:0]               m_tdata;  // green_on, red_on, busy_res, zero pad

    led_blink_code_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Sequencer model: register copies and sequence state at the block's
    // widths. Registers start at their reset values.
    // ------------------------------------------------------------------------
    logic [TimeWidth-1:0]         t_off   = OffTimeReset;
    logic [TimeWidth-1:0]         t_gap   = GapTimeReset;
    logic [TimeWidth-1:0]         t_short = ShortOnTimeReset;
    logic [TimeWidth-1:0]         t_long  = LongOnTimeReset;
    logic [WeightWidth-1:0]       w_long  = LongWeightReset;

    logic [TimeWidth-1:0]         left_ticks    = '0;
    logic [SolarCountWidth-1:0]   solar_units   = '0;
    logic [BatteryCountWidth-1:0] battery_units = '0;
    logic [LoadCountWidth-1:0]    load_units    = '0;
    logic [UnitsWidth-1:0]        units_done    = '0;
    logic                         lamp_on       = 1'b0;
    logic                         green_lvl     = 1'b0;
    logic                         red_lvl       = 1'b0;

    // LED results predicted for accepted transactions, oldest first.
    result_t pending_leds[$];

    // Bookkeeping.
    int  cycle_count     = 0;
    int  mismatches      = 0;
    int  results_checked = 0;
    int  starts_sent     = 0;
    int  ticks_sent      = 0;
    int  settings_loaded = 0;
    int  burst_left      = 0;
    bit  tx_gaps_on      = 1'b0;
    bit  rx_stalls_on    = 1'b0;

    // A duration register of zero behaves as one tick.
    function automatic logic [TimeWidth-1:0] nonzero_time(logic [TimeWidth-1:0] v);
        return (v == 0) ? 16'd1 : v;
    endfunction

    // The sequence is over once the LED is dark and every unit has been shown.
    function automatic bit sequence_over();
        int total;
        total = solar_units + battery_units + load_units;
        return !lamp_on && (int'(units_done) >= total);
    endfunction

    // Light one pulse of the current measurement, of which 'shown' units out
    // of 'count' are already done. A long pulse is used when it fits.
    function automatic logic [TimeWidth-1:0] light_pulse(int shown, int count,
                                                         logic g, logic r);
        int w;
        w = (w_long == 0) ? 1 : int'(w_long);
        green_lvl = g;
        red_lvl   = r;
        lamp_on   = 1'b1;
        if (shown + w <= count) begin
            units_done = UnitsWidth'(int'(units_done) + w);
            return nonzero_time(t_long);
        end
        units_done = UnitsWidth'(int'(units_done) + 1);
        return nonzero_time(t_short);
    endfunction

    // One step of the sequence: count down, or make the next LED transition.
    function automatic void step_sequence();
        logic [TimeWidth-1:0] dur;
        int                   first_two;
        if (sequence_over())
            return;
        if (left_ticks > 1) begin
            left_ticks = left_ticks - 16'd1;
            return;
        end
        first_two = solar_units + battery_units;
        if (lamp_on) begin
            green_lvl = 1'b0;
            red_lvl   = 1'b0;
            lamp_on   = 1'b0;
            // The last pulse of solar or battery is followed by the long gap.
            if (int'(units_done) == int'(solar_units) || int'(units_done) == first_two)
                dur = nonzero_time(t_gap);
            else
                dur = nonzero_time(t_off);
        end else if (units_done < solar_units) begin
            dur = light_pulse(units_done, solar_units, 1'b1, 1'b0);
        end else if (int'(units_done) - int'(solar_units) < int'(battery_units)) begin
            dur = light_pulse(int'(units_done) - int'(solar_units), battery_units,
                              1'b1, 1'b1);
        end else begin
            dur = light_pulse(int'(units_done) - first_two, load_units, 1'b0, 1'b1);
        end
        // An overdue step carries its remainder so the schedule keeps its grid.
        left_ticks = left_ticks + dur - 16'd1;
    endfunction

    // Predict the LED result of one accepted transaction.
    function automatic result_t blink_predict(logic op, logic [15:0] solar_mw,
                                              logic [15:0] batt_mv, logic [15:0] load_mw);
        result_t res;
        if (op == OP_START) begin
            solar_units   = SolarCountWidth'((int'(solar_mw) + 500) / 1000);
            battery_units = BatteryCountWidth'((int'(batt_mv) + 100) / 200);
            load_units    = LoadCountWidth'((int'(load_mw) + 500) / 1000);
            units_done    = '0;
            lamp_on       = 1'b0;
            left_ticks    = '0;
        end
        step_sequence();
        res.green_on = green_lvl;
        res.red_on   = red_lvl;
        res.busy_res = !sequence_over();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge only.
    // ------------------------------------------------------------------------

    // Write one register; the model copy follows at once, since writes are
    // only made while no transaction is in flight.
    task automatic set_register(cfg_index_t idx, logic [TimeWidth-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_OFF_TIME:      t_off   = value;
            REG_GAP_TIME:      t_gap   = value;
            REG_SHORT_ON_TIME: t_short = value;
            REG_LONG_ON_TIME:  t_long  = value;
            REG_LONG_WEIGHT:   w_long  = value[WeightWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [15:0] off_t, logic [15:0] gap_t,
                                 logic [15:0] short_t, logic [15:0] long_t,
                                 logic [3:0] weight);
        set_register(REG_OFF_TIME, off_t);
        set_register(REG_GAP_TIME, gap_t);
        set_register(REG_SHORT_ON_TIME, short_t);
        set_register(REG_LONG_ON_TIME, long_t);
        set_register(REG_LONG_WEIGHT, {12'd0, weight});
        settings_loaded++;
    endtask

    // Send one transaction. In gap mode the sender works in bursts with idle
    // cycles between them. tvalid is only lowered when a gap starts, so it is
    // never lowered and raised within one time step.
    task automatic send_item(logic op, logic [15:0] solar_mw,
                             logic [15:0] batt_mv, logic [15:0] load_mw);
        @(negedge aclk);
        if (tx_gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {load_mw, batt_mv, solar_mw};
        do @(posedge aclk); while (!s_tready);
        pending_leds.push_back(blink_predict(op, solar_mw, batt_mv, load_mw));
        if (op == OP_START)
            starts_sent++;
        else
            ticks_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Wait until every predicted result has been seen, then let the pipeline
    // settle so a register write cannot overlap a step.
    task automatic wait_for_results();
        while (pending_leds.size() != 0)
            @(posedge aclk);
        repeat (Latency + 2) @(posedge aclk);
    endtask

    // Receiver: m_tready steps through the bits of a random 8-bit pattern that is
    // reloaded when the phase counter wraps. Bit 0 is always set so the result
    // channel keeps moving.
    logic [7:0] rx_pattern = 8'hFF;
    logic [2:0] rx_phase   = '0;

    always @(negedge aclk) begin
        if (rx_phase == 0)
            rx_pattern <= 8'($urandom) | 8'd1;
        rx_phase <= rx_phase + 3'd1;
        m_tready <= !rx_stalls_on || rx_pattern[rx_phase];
    end

    // ------------------------------------------------------------------------
    // Result checking, sampled on the rising edge.
    // ------------------------------------------------------------------------
    result_t got_leds;
    result_t want_leds;

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_leds.green_on = m_tdata[0];
            got_leds.red_on   = m_tdata[1];
            got_leds.busy_res = m_tdata[2];
            if (pending_leds.size() == 0) begin
                note_mismatch($sformatf("unexpected result g=%b r=%b busy=%b",
                              got_leds.green_on, got_leds.red_on, got_leds.busy_res));
            end else begin
                want_leds = pending_leds.pop_front();
                results_checked++;
                if (got_leds.green_on !== want_leds.green_on ||
                    got_leds.red_on !== want_leds.red_on ||
                    got_leds.busy_res !== want_leds.busy_res)
                    note_mismatch($sformatf(
                        "result %0d: expected g=%b r=%b busy=%b, got g=%b r=%b busy=%b",
                        results_checked, want_leds.green_on, want_leds.red_on,
                        want_leds.busy_res, got_leds.green_on, got_leds.red_on,
                        got_leds.busy_res));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     CycleLimit, pending_leds.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Readings just below a rounding step give zero pulses; just at the step
    // they give one. Tick transactions carry all-ones or zero data that must be
    // ignored.
    task automatic test_rounding_edges();
        send_item(OP_START, 16'd499, 16'd99, 16'd499);
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_START, 16'd500, 16'd100, 16'd500);
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // A start with zero counts while the green element is lit leaves the
    // levels alone but reports the sequence as finished.
    task automatic test_start_while_lit();
        send_item(OP_START, 16'd0, 16'd0, 16'd0);
        send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'hA5A5, 16'h5A5A, 16'hFFFF);
    endtask

    // Full-scale readings, then a restart in the middle of that sequence.
    task automatic test_full_scale_restart();
        send_item(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_START, 16'd1500, 16'd300, 16'd1500);
        repeat (2) send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // All registers at zero behave as one tick and a weight of one, so a
    // short sequence plays out within a few ticks.
    task automatic test_zero_registers();
        stop_sending();
        wait_for_results();
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
        send_item(OP_START, 16'd2000, 16'd200, 16'd1000);
        repeat (8) send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Several register settings, each followed by random traffic. Most of it
    // is ticks, so sequences run far; starts come now and then as restarts.
    task automatic test_random_traffic();
        logic        op;
        logic [15:0] solar_mw;
        logic [15:0] batt_mv;
        logic [15:0] load_mw;
        int          pick;
        for (int phase = 0; phase < Phases; phase++) begin
            stop_sending();
            wait_for_results();
            case (phase)
                0: load_settings(16'd1, 16'd1, 16'd1, 16'd1, 4'd1);
                1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
                default: load_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                       16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                       4'($urandom_range(0, 15)));
            endcase
            // Phase 0 runs with neither side idling.
            tx_gaps_on   = phase[0];
            rx_stalls_on = phase[1];
            for (int n = 0; n < PhaseItems; n++) begin
                op = (n == 0 || $urandom_range(0, 39) == 0) ? OP_START : OP_TICK;
                solar_mw = 16'($urandom_range(0, 65535));
                batt_mv  = 16'($urandom_range(0, 65535));
                load_mw  = 16'($urandom_range(0, 65535));
                if (op == OP_START) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        // Small readings so the whole sequence can finish.
                        solar_mw = 16'($urandom_range(0, 6000));
                        batt_mv  = 16'($urandom_range(0, 3000));
                        load_mw  = 16'($urandom_range(0, 6000));
                    end else if (pick == 9) begin
                        // Right at a rounding step, one side or the other.
                        solar_mw = 16'($urandom_range(0, 65) * 1000 + 499 + $urandom_range(0, 1));
                        batt_mv  = 16'($urandom_range(0, 326) * 200 + 99 + $urandom_range(0, 1));
                        load_mw  = 16'($urandom_range(0, 65) * 1000 + 499 + $urandom_range(0, 1));
                    end
                end
                send_item(op, solar_mw, batt_mv, load_mw);
                // Now and then hold the sender until the pipeline is empty.
                if ($urandom_range(0, 99) == 0) begin
                    stop_sending();
                    wait_for_results();
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_rounding_edges();
        test_start_while_lit();
        test_full_scale_restart();
        test_zero_registers();
        test_random_traffic();

        stop_sending();
        wait_for_results();
        repeat (Latency + 4) @(posedge aclk);

        if (pending_leds.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_leds.size()));

        $display("Sent %0d starts and %0d ticks across %0d register settings.",
                 starts_sent, ticks_sent, settings_loaded);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
